### rtl/cal_pkg.sv
// Shared types, codes, reset values and a divide-by-100 helper function for the calendar clock.
`default_nettype none

package cal_pkg;

    localparam logic [13:0] YEAR_MIN   = 14'd1;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    // floor(v / 100) == (v * 5243) >> 19 for every 14-bit v.
    localparam int unsigned DIV100_MUL = 5243;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADJUST = 2'd1,
        OP_PRESET = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        FLD_SEC   = 3'd0,
        FLD_MIN   = 3'd1,
        FLD_HOUR  = 3'd2,
        FLD_DAY   = 3'd3,
        FLD_MONTH = 3'd4,
        FLD_YEAR  = 3'd5
    } fld_t;

    typedef struct packed {
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [2:0]  wday;
        logic        leap;
        logic [4:0]  mlen;
    } cal_state_t;

    // 12:00:00, Wednesday February 28 2007. The preset loads the same date.
    localparam cal_state_t CAL_RESET = '{
        sec:   6'd0,
        min:   6'd0,
        hour:  5'd12,
        day:   5'd28,
        month: 4'd2,
        year:  14'd2007,
        wday:  3'd3,
        leap:  1'b0,
        mlen:  5'd28
    };

    function automatic logic [6:0] div100(input logic [13:0] v);
        logic [26:0] prod;
        prod = 27'(v) * 27'(DIV100_MUL);
        return prod[25:19];
    endfunction

endpackage

`default_nettype wire

### rtl/cal_wday.sv
// Weekday from a Gregorian date with a Zeller-style congruence.
`default_nettype none

module cal_wday (
    input  wire logic [4:0]  day,
    input  wire logic [3:0]  month,
    input  wire logic [13:0] year,
    output logic      [2:0]  wday
);

    // (31 * m) / 12 where January and February count as months 11 and 12
    // of the year before.
    function automatic logic [4:0] month_offset(input logic [3:0] mon);
        logic [4:0] ofs;
        case (mon)
            4'd1:    ofs = 5'd28;
            4'd2:    ofs = 5'd31;
            4'd3:    ofs = 5'd2;
            4'd4:    ofs = 5'd5;
            4'd5:    ofs = 5'd7;
            4'd6:    ofs = 5'd10;
            4'd7:    ofs = 5'd12;
            4'd8:    ofs = 5'd15;
            4'd9:    ofs = 5'd18;
            4'd10:   ofs = 5'd20;
            4'd11:   ofs = 5'd23;
            4'd12:   ofs = 5'd25;
            default: ofs = 5'd0;
        endcase
        return ofs;
    endfunction

    // Since 8 is 1 modulo 7, octal digits are summed twice, then one
    // conditional subtract finishes the reduction.
    function automatic logic [2:0] mod7(input logic [14:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] r;
        s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        r  = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
        return (r == 4'd7) ? 3'd0 : r[2:0];
    endfunction

    logic        early;
    logic [13:0] y_adj;
    logic [6:0]  cent;
    logic [14:0] total;

    always_comb
    begin
        early = (month <= 4'd2);
        y_adj = year - 14'(early);
        cent  = cal_pkg::div100(y_adj);
        total = 15'(day) + 15'(y_adj) + 15'(y_adj >> 2) + 15'(cent >> 2)
              + 15'(month_offset(month)) - 15'(cent);
        wday  = mod7(total);
    end

endmodule

`default_nettype wire

### rtl/cal_next.sv
// Next-state logic of the calendar clock for one command item.
`default_nettype none

module cal_next (
    input  wire cal_pkg::cal_state_t cur,
    input  wire cal_pkg::op_t        op,
    input  wire logic [2:0]          field_sel,
    input  wire logic                step_up,
    output cal_pkg::cal_state_t      nxt
);

    function automatic logic leap_of(input logic [13:0] yr);
        logic [6:0]  q;
        logic [13:0] hund;
        q    = cal_pkg::div100(yr);
        hund = 14'(q) * 14'(100);
        return (yr[1:0] == 2'b00) && ((yr != hund) || (q[1:0] == 2'b00));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] mon, input logic lp);
        logic [4:0] len;
        case (mon) inside
            4'd2:                    len = 5'd28 + 5'(lp);
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    cal_pkg::fld_t fld;
    logic [13:0]   yr_up;
    logic [13:0]   yr_dn;
    logic [13:0]   yr_step;
    logic [13:0]   lyear;
    logic          leap_new;
    logic          mon_roll;
    logic [3:0]    mon_tick;
    logic          leap_tick;
    logic [3:0]    mon_adj;
    logic [3:0]    len_mon;
    logic          len_leap;
    logic [4:0]    mlen_new;
    logic [4:0]    day_clamp;
    logic [5:0]    day_inc;
    logic [4:0]    wd_day;
    logic [3:0]    wd_month;
    logic [13:0]   wd_year;
    logic [2:0]    wd_new;

    cal_wday u_wday (
        .day   (wd_day),
        .month (wd_month),
        .year  (wd_year),
        .wday  (wd_new)
    );

    always_comb
    begin
        fld      = cal_pkg::fld_t'(field_sel);
        yr_up    = (cur.year < cal_pkg::YEAR_MAX) ? cur.year + 14'd1 : cur.year;
        yr_dn    = (cur.year > cal_pkg::YEAR_MIN) ? cur.year - 14'd1 : cur.year;
        yr_step  = step_up ? yr_up : yr_dn;
        lyear    = (op == cal_pkg::OP_TICK) ? yr_up : yr_step;
        leap_new = leap_of(lyear);

        mon_roll  = (cur.month >= 4'd12);
        mon_tick  = mon_roll ? 4'd1 : cur.month + 4'd1;
        leap_tick = mon_roll ? leap_new : cur.leap;

        if (step_up)
            mon_adj = (cur.month < 4'd12) ? cur.month + 4'd1 : 4'd1;
        else
            mon_adj = (cur.month == 4'd1) ? 4'd12 : cur.month - 4'd1;

        // One month-length lookup serves the tick rollover and both adjusts.
        if (op == cal_pkg::OP_ADJUST && fld == cal_pkg::FLD_MONTH)
        begin
            len_mon  = mon_adj;
            len_leap = cur.leap;
        end
        else if (op == cal_pkg::OP_ADJUST && fld == cal_pkg::FLD_YEAR)
        begin
            len_mon  = cur.month;
            len_leap = leap_new;
        end
        else
        begin
            len_mon  = mon_tick;
            len_leap = leap_tick;
        end
        mlen_new  = month_len(len_mon, len_leap);
        day_clamp = (cur.day > mlen_new) ? mlen_new : cur.day;
        day_inc   = 6'(cur.day) + 6'd1;

        if (fld == cal_pkg::FLD_MONTH)
        begin
            wd_day   = day_clamp;
            wd_month = mon_adj;
            wd_year  = cur.year;
        end
        else
        begin
            wd_day   = cur.day;
            wd_month = cur.month;
            wd_year  = yr_step;
        end

        nxt = cur;
        unique case (op)
            cal_pkg::OP_TICK:
            begin
                if (cur.sec < 6'd59)
                    nxt.sec = cur.sec + 6'd1;
                else
                begin
                    nxt.sec = 6'd0;
                    if (cur.min < 6'd59)
                        nxt.min = cur.min + 6'd1;
                    else
                    begin
                        nxt.min = 6'd0;
                        if (cur.hour < 5'd23)
                            nxt.hour = cur.hour + 5'd1;
                        else
                        begin
                            nxt.hour = 5'd0;
                            nxt.wday = (cur.wday >= 3'd6) ? 3'd0 : cur.wday + 3'd1;
                            if (day_inc <= 6'(cur.mlen))
                                nxt.day = day_inc[4:0];
                            else
                            begin
                                nxt.day   = 5'd1;
                                nxt.month = mon_tick;
                                if (mon_roll)
                                begin
                                    nxt.year = yr_up;
                                    nxt.leap = leap_new;
                                end
                                nxt.mlen = mlen_new;
                            end
                        end
                    end
                end
            end
            cal_pkg::OP_ADJUST:
            begin
                unique case (fld)
                    cal_pkg::FLD_SEC:
                        nxt.sec = 6'd0;
                    cal_pkg::FLD_MIN:
                        if (step_up)
                            nxt.min = (cur.min < 6'd59) ? cur.min + 6'd1 : 6'd0;
                        else
                            nxt.min = (cur.min == 6'd0) ? 6'd59 : cur.min - 6'd1;
                    cal_pkg::FLD_HOUR:
                        if (step_up)
                            nxt.hour = (cur.hour < 5'd23) ? cur.hour + 5'd1 : 5'd0;
                        else
                            nxt.hour = (cur.hour == 5'd0) ? 5'd23 : cur.hour - 5'd1;
                    cal_pkg::FLD_DAY:
                        if (step_up)
                        begin
                            nxt.day  = (cur.day < cur.mlen) ? cur.day + 5'd1 : 5'd1;
                            nxt.wday = (cur.wday < 3'd6) ? cur.wday + 3'd1 : 3'd0;
                        end
                        else
                        begin
                            nxt.day  = (cur.day == 5'd1) ? cur.mlen : cur.day - 5'd1;
                            nxt.wday = (cur.wday == 3'd0) ? 3'd6 : cur.wday - 3'd1;
                        end
                    cal_pkg::FLD_MONTH:
                    begin
                        nxt.month = mon_adj;
                        nxt.mlen  = mlen_new;
                        nxt.day   = day_clamp;
                        nxt.wday  = wd_new;
                    end
                    cal_pkg::FLD_YEAR:
                    begin
                        nxt.year = yr_step;
                        nxt.leap = leap_new;
                        nxt.mlen = mlen_new;
                        nxt.wday = wd_new;
                    end
                    default:
                        nxt = cur;
                endcase
            end
            cal_pkg::OP_PRESET:
            begin
                nxt     = cal_pkg::CAL_RESET;
                nxt.sec = cur.sec;
            end
            default:
                nxt = cur;
        endcase
    end

endmodule

`default_nettype wire

### rtl/calendar_clock_with_adjust.sv
// Top level of the Gregorian calendar clock with tick, field adjust and preset.
`default_nettype none

// Gregorian calendar clock. Each command item is a one-second tick, an
// adjust of one field (clear seconds, or step minute, hour, day with
// weekday, month or year up or down) or a preset to 12:00 on February 28
// 2007 that keeps the seconds. Every item yields exactly one result item
// carrying the full clock state after that item. The block takes one item
// per cycle while cmd_stall is low: an accepted item sits in the command
// register, the next-state pass (month length, day clamp, leap test and
// the weekday congruence with its constant divide by 100 and modulo-7
// fold) works combinationally on it, and the clock state register, which
// also serves as the result register, then loads the new state. The
// command register takes a new item while a result is still held by
// rslt_stall; cmd_stall rises only when both registers are full. Month
// adjust clamps the day to the new month length; year adjust saturates at
// 1 and 9999 and does not clamp the day, so the day may exceed the month
// length until the next rollover or day adjust.
// Reset loads Wednesday February 28 2007, 12:00:00.
module calendar_clock_with_adjust (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire logic [1:0]  op,
    input  wire logic [2:0]  field_sel,
    input  wire logic        step_up,
    output logic             rslt_valid,
    input  wire logic        rslt_stall,
    output logic      [5:0]  sec_out,
    output logic      [5:0]  min_out,
    output logic      [4:0]  hour_out,
    output logic      [4:0]  day_out,
    output logic      [3:0]  month_out,
    output logic      [13:0] year_out,
    output logic      [2:0]  weekday_out,
    output logic             leap_out,
    output logic      [4:0]  month_len_out
);

    logic                cmd_vld_reg;
    cal_pkg::op_t        op_reg;
    logic [2:0]          sel_reg;
    logic                up_reg;
    cal_pkg::cal_state_t state_reg;
    cal_pkg::cal_state_t state_next;
    logic                rslt_vld_reg;
    logic                advance;
    logic                cmd_take;

    // The command register moves into the state whenever the result side
    // is free or is being drained in this cycle.
    assign advance   = cmd_vld_reg && !(rslt_vld_reg && rslt_stall);
    assign cmd_stall = cmd_vld_reg && !advance;
    assign cmd_take  = cmd_valid && !cmd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_vld_reg <= 1'b0;
        else if (!cmd_stall)
            cmd_vld_reg <= cmd_valid;
    end

    // Command payload needs no reset; it is qualified by cmd_vld_reg.
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            op_reg  <= cal_pkg::op_t'(op);
            sel_reg <= field_sel;
            up_reg  <= step_up;
        end
    end

    cal_next u_next (
        .cur       (state_reg),
        .op        (op_reg),
        .field_sel (sel_reg),
        .step_up   (up_reg),
        .nxt       (state_next)
    );

    // The clock state is the result payload, so it only changes when the
    // previous result has left.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cal_pkg::CAL_RESET;
            rslt_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                state_reg <= state_next;
            if (advance)
                rslt_vld_reg <= 1'b1;
            else if (!rslt_stall)
                rslt_vld_reg <= 1'b0;
        end
    end

    assign rslt_valid    = rslt_vld_reg;
    assign sec_out       = state_reg.sec;
    assign min_out       = state_reg.min;
    assign hour_out      = state_reg.hour;
    assign day_out       = state_reg.day;
    assign month_out     = state_reg.month;
    assign year_out      = state_reg.year;
    assign weekday_out   = state_reg.wday;
    assign leap_out      = state_reg.leap;
    assign month_len_out = state_reg.mlen;

endmodule

`default_nettype wire

### rtl/cal_chk.sv
// Port-level checker for the calendar clock and its bind to the top level.
`default_nettype none

module cal_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cmd_valid,
    input wire logic        cmd_stall,
    input wire logic [1:0]  op,
    input wire logic [2:0]  field_sel,
    input wire logic        step_up,
    input wire logic        rslt_valid,
    input wire logic        rslt_stall,
    input wire logic [5:0]  sec_out,
    input wire logic [5:0]  min_out,
    input wire logic [4:0]  hour_out,
    input wire logic [4:0]  day_out,
    input wire logic [3:0]  month_out,
    input wire logic [13:0] year_out,
    input wire logic [2:0]  weekday_out,
    input wire logic        leap_out,
    input wire logic [4:0]  month_len_out
);

    // A held result keeps its whole payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid && rslt_stall |=> rslt_valid && $stable(sec_out) && $stable(min_out)
            && $stable(hour_out) && $stable(day_out) && $stable(month_out)
            && $stable(year_out) && $stable(weekday_out) && $stable(leap_out)
            && $stable(month_len_out))
        else $error("result payload changed while stalled");

    // An accepted item passes through the command register and shows up as a
    // result when the result side is free.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) ##1 !(rslt_valid && rslt_stall) |=> rslt_valid)
        else $error("accepted item produced no result");

    a_time: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid |-> sec_out < 6'd60 && min_out < 6'd60 && hour_out < 5'd24
            && weekday_out < 3'd7 && month_out >= 4'd1 && month_out <= 4'd12)
        else $error("time of day or month out of range");

    a_short_month: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid && (month_out == 4'd4 || month_out == 4'd6 || month_out == 4'd9
            || month_out == 4'd11) |-> month_len_out == 5'd30)
        else $error("month length wrong for a thirty-day month");

    a_feb: assert property (@(posedge clk) disable iff (!rst_n)
        rslt_valid && month_out == 4'd2 |-> month_len_out == 5'd28 + 5'(leap_out)
            && !(leap_out && year_out[1:0] != 2'b00))
        else $error("February length or leap flag inconsistent");

endmodule

bind calendar_clock_with_adjust cal_chk u_cal_chk (.*);

`default_nettype wire
